// ----- design/fmcp_pkg.sv -----
// Shared types, frame constants and the duty split function for the
// framed motor command parser. No dependencies.
package fmcp_pkg;

   localparam logic [7:0] START_MOTOR      = 8'hAA;
   localparam logic [7:0] START_CMD        = 8'hAB;
   localparam logic [7:0] FRAME_END        = 8'h55;
   localparam logic [7:0] MAX_LEN_RESET    = 8'd95;
   localparam logic [7:0] MOTOR_DATA_BYTES = 8'd4;
   localparam logic signed [15:0] DUTY_MAX = 16'sd255;

   typedef enum logic [1:0] {
      KIND_MOTOR    = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_ACCEPTED = 2'd2,
      KIND_DROPPED  = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_MOTOR = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_END   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] fwd;
      logic [7:0] rev;
   } duty_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
      logic [7:0]         left_fwd_duty;
      logic [7:0]         left_rev_duty;
      logic [7:0]         right_fwd_duty;
      logic [7:0]         right_rev_duty;
      logic [7:0]         payload_byte;
   } result_type;

   // clamp to +/-255 and split into forward and reverse duty
   function automatic duty_type split_duty(input logic signed [15:0] v);
      duty_type d;
      logic signed [16:0] neg;
      d   = '0;
      neg = -17'(v);
      if (v > DUTY_MAX) begin
         d.fwd = 8'hFF;
      end else if (v > 16'sd0) begin
         d.fwd = v[7:0];
      end
      if (v < -DUTY_MAX) begin
         d.rev = 8'hFF;
      end else if (v < 16'sd0) begin
         d.rev = neg[7:0];
      end
      return d;
   endfunction

endpackage

// ----- design/framed_motor_command_parser.sv -----
// Top level of the framed motor command parser: configuration register,
// frame parser and result buffer. Uses fmcp_pkg, fmcp_parser, fmcp_out_buf.
// A result is registered, via the skid stage if rsp_ stalls, before it shows on rsp_.
// Throughput: one word per cycle; req_ready drops only while both the result
// register and the skid stage are full.
// Reset: synchronous; parser returns to idle, no results pending, limit is 95.
module framed_motor_command_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_left_command,
   output logic signed [15:0] rsp_right_command,
   output logic [7:0]         rsp_left_fwd_duty,
   output logic [7:0]         rsp_left_rev_duty,
   output logic [7:0]         rsp_right_fwd_duty,
   output logic [7:0]         rsp_right_rev_duty,
   output logic [7:0]         rsp_payload_byte,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_max_payload_len
);

   logic [7:0] max_len_ff;
   logic word_take;
   logic res_valid;
   fmcp_pkg::result_type res, out_res;

   assign csr_ready = 1'b1;
   assign word_take = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= fmcp_pkg::MAX_LEN_RESET;
      end else if (csr_valid) begin
         max_len_ff <= csr_max_payload_len;
      end
   end

   fmcp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .word_take       (word_take),
      .rx_byte         (req_rx_byte),
      .max_payload_len (max_len_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   fmcp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (word_take & res_valid),
      .push_res   (res),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_res    (out_res)
   );

   assign rsp_kind           = out_res.kind;
   assign rsp_left_command   = out_res.left_command;
   assign rsp_right_command  = out_res.right_command;
   assign rsp_left_fwd_duty  = out_res.left_fwd_duty;
   assign rsp_left_rev_duty  = out_res.left_rev_duty;
   assign rsp_right_fwd_duty = out_res.right_fwd_duty;
   assign rsp_right_rev_duty = out_res.right_rev_duty;
   assign rsp_payload_byte   = out_res.payload_byte;

endmodule

// ----- design/fmcp_parser.sv -----
// Frame parser: phase state, counters and motor byte shift register, and
// the result built from them for each word that gives one. Uses fmcp_pkg.
module fmcp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 word_take,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           max_payload_len,
   output logic                 res_valid,
   output fmcp_pkg::result_type res
);

   fmcp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [31:0] motor_bytes_ff, motor_bytes_in;
   fmcp_pkg::duty_type left_duty, right_duty;
   logic [7:0]  count_inc;

   assign left_duty  = fmcp_pkg::split_duty(motor_bytes_ff[31:16]);
   assign right_duty = fmcp_pkg::split_duty(motor_bytes_ff[15:0]);
   assign count_inc  = byte_count_ff + 8'd1;

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      motor_bytes_in  = motor_bytes_ff;
      res_valid       = 1'b0;
      res             = '0;
      case (phase_ff)
         fmcp_pkg::PH_MOTOR: begin
            if (byte_count_ff < fmcp_pkg::MOTOR_DATA_BYTES) begin
               motor_bytes_in = {motor_bytes_ff[23:0], rx_byte};
               byte_count_in  = count_inc;
            end else begin
               phase_in      = fmcp_pkg::PH_IDLE;
               byte_count_in = '0;
               if (rx_byte == fmcp_pkg::FRAME_END) begin
                  res_valid          = 1'b1;
                  res.kind           = fmcp_pkg::KIND_MOTOR;
                  res.left_command   = motor_bytes_ff[31:16];
                  res.right_command  = motor_bytes_ff[15:0];
                  res.left_fwd_duty  = left_duty.fwd;
                  res.left_rev_duty  = left_duty.rev;
                  res.right_fwd_duty = right_duty.fwd;
                  res.right_rev_duty = right_duty.rev;
               end
            end
         end
         fmcp_pkg::PH_LEN: begin
            frame_length_in = rx_byte;
            byte_count_in   = '0;
            if (rx_byte == 8'd0 || rx_byte > max_payload_len) begin
               phase_in = fmcp_pkg::PH_IDLE;
            end else begin
               phase_in = fmcp_pkg::PH_DATA;
            end
         end
         fmcp_pkg::PH_DATA: begin
            byte_count_in = count_inc;
            if (count_inc >= frame_length_ff) begin
               phase_in = fmcp_pkg::PH_END;
            end
            res_valid        = 1'b1;
            res.kind         = fmcp_pkg::KIND_PAYLOAD;
            res.payload_byte = rx_byte;
         end
         fmcp_pkg::PH_END: begin
            phase_in      = fmcp_pkg::PH_IDLE;
            byte_count_in = '0;
            res_valid     = 1'b1;
            res.kind      = (rx_byte == fmcp_pkg::FRAME_END) ? fmcp_pkg::KIND_ACCEPTED
                                                              : fmcp_pkg::KIND_DROPPED;
         end
         default: begin
            phase_in = fmcp_pkg::PH_IDLE;
            if (rx_byte == fmcp_pkg::START_MOTOR) begin
               phase_in      = fmcp_pkg::PH_MOTOR;
               byte_count_in = '0;
            end else if (rx_byte == fmcp_pkg::START_CMD) begin
               phase_in = fmcp_pkg::PH_LEN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= fmcp_pkg::PH_IDLE;
         byte_count_ff   <= '0;
         frame_length_ff <= '0;
         motor_bytes_ff  <= '0;
      end else if (word_take) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         motor_bytes_ff  <= motor_bytes_in;
      end
   end

   a_data_count_below_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == fmcp_pkg::PH_DATA |-> byte_count_ff < frame_length_ff)
      else $error("payload count reached frame length while still in payload");

   a_motor_count_bounded: assert property (@(posedge clock) disable iff (reset)
      phase_ff == fmcp_pkg::PH_MOTOR |-> byte_count_ff <= fmcp_pkg::MOTOR_DATA_BYTES)
      else $error("motor byte count overran");

endmodule

// ----- design/fmcp_out_buf.sv -----
// Result register with a skid stage, so a new word is taken while a
// finished result waits. Uses fmcp_pkg.
module fmcp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fmcp_pkg::result_type push_res,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fmcp_pkg::result_type out_res
);

   logic main_valid_ff, main_valid_in;
   logic skid_valid_ff, skid_valid_in;
   fmcp_pkg::result_type main_ff, main_in;
   fmcp_pkg::result_type skid_ff, skid_in;
   logic pop;

   assign pop        = main_valid_ff & out_ready;
   assign push_ready = ~skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_res    = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a word while result register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("word pushed while both stages are full");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready && !skid_valid_ff && push) |=> skid_valid_ff)
      else $error("stalled push did not land in skid stage");

endmodule
